>>> rtl/gdoy_pkg.sv
// Shared types, constants and the month-length table for the Gregorian
// day-of-year converter. No dependencies.
package gdoy_pkg;

  localparam logic REQ_TO_YDAY = 1'b0;
  localparam logic REQ_TO_DATE = 1'b1;

  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 9;
  localparam int unsigned DOM_W   = 5;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAYS_YEAR = 9'd365;
  localparam logic [DAY_W-1:0]   DAYS_LEAP = 9'd366;

  // y is a multiple of 25 iff (y * 25^-1 mod 2^16) <= floor(65535 / 25)
  localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MONTH = 2'd1,
    ST_BAD_DAY   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_WALK
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic check;
    logic step;
    logic store;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_busy;
  } dp_sts_t;

  function automatic logic [DOM_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DOM_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/gregorian_day_of_year_converter.sv
// Top level of the Gregorian day-of-year converter: joins the sequencer and
// the datapath to the stream ports. Depends on gdoy_pkg, gdoy_ctrl, gdoy_dp.
//
// Usage:
//   Slave side takes one request word: tuser selects the direction
//   (0 = date to day of year, 1 = day of year to date), tdata carries year,
//   month and day number. Master side returns one result word per request:
//   status, day of year, month and day of month; error results carry zeros.
//   One request is in work at a time; s_axis_tready_o is high only while the
//   converter is idle.
//   After acceptance the sequencer runs the leap test and range check, then one
//   walk step per month walked (month - 1 forward, up to 11 inverse), then loads
//   the result register, which raises m_axis_tvalid_o.
//   The month walk is the only step whose length depends on the request.
//   A new request is taken in the cycle after the result is stored; the result word
//   may wait in its register while the next request is worked.
//   If the receiver stalls with a word pending, the next result waits in the
//   walk step until the register frees.
//   Reset (rst_ni low) empties the result register and returns to idle.
module gregorian_day_of_year_converter
  import gdoy_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // year[15:0], month_in[19:16], day_number[28:20]
  input  logic [0:0]  s_axis_tuser_i,   // req_type[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // status[1:0], year_day[10:2], month_out[14:11],
                                        // day_out[19:15]
);

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [1:0]         status;
  logic [DAY_W-1:0]   year_day;
  logic [MONTH_W-1:0] month_out;
  logic [DOM_W-1:0]   day_out;

  gdoy_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gdoy_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (s_axis_tuser_i[0]),
    .year_i       (s_axis_tdata_i[15:0]),
    .month_in_i   (s_axis_tdata_i[19:16]),
    .day_number_i (s_axis_tdata_i[28:20]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_o     (status),
    .year_day_o   (year_day),
    .month_out_o  (month_out),
    .day_out_o    (day_out)
  );

  assign m_axis_tdata_o = {4'b0000, day_out, month_out, year_day, status};

endmodule

>>> rtl/gdoy_ctrl.sv
// Sequencer for the day-of-year converter: input handshake and the
// load / leap / check / month-walk / store steps. Depends on gdoy_pkg.
module gdoy_ctrl
  import gdoy_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_WALK;
      end
      S_WALK: begin
        if (!sts_i.walk_done) begin
          cmd_o.step = 1'b1;
        end else if (!sts_i.out_busy) begin
          cmd_o.store = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  a_step_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !sts_i.walk_done)
    else $error("month walk stepped past its end");

  a_store_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store |-> !sts_i.out_busy)
    else $error("result stored over an undelivered word");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_MUL))
    else $error("accepted word did not start the sequence");

endmodule

>>> rtl/gdoy_dp.sv
// Datapath for the day-of-year converter: request registers, leap-year test,
// range checks, month-walk accumulator and result register. Depends on gdoy_pkg.
module gdoy_dp
  import gdoy_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic               req_type_i,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_in_i,
  input  logic [DAY_W-1:0]   day_number_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [DAY_W-1:0]   year_day_o,
  output logic [MONTH_W-1:0] month_out_o,
  output logic [DOM_W-1:0]   day_out_o
);

  logic               req_q;
  logic [YEAR_W-1:0]  year_q;
  logic [MONTH_W-1:0] month_q;
  logic [DAY_W-1:0]   acc_q, acc_d;
  logic [YEAR_W-1:0]  prod_q;
  logic               leap_q;
  status_e            status_q, status_d;
  logic [MONTH_W-1:0] idx_q, idx_d;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [DAY_W-1:0]   out_yday_q;
  logic [MONTH_W-1:0] out_month_q;
  logic [DOM_W-1:0]   out_day_q;

  logic [2*YEAR_W-1:0] prod_full;
  logic                div25, leap_c;
  logic [DOM_W-1:0]    chk_len, walk_len;
  logic                walk_done;
  logic                ok_fwd, ok_inv;

  assign prod_full = year_q * INV25;
  assign div25     = (prod_q <= DIV25_MAX);
  assign leap_c    = ((year_q[1:0] == 2'b00) && !div25) ||
                     ((year_q[3:0] == 4'b0000) && div25);
  assign chk_len   = month_len(leap_c, month_q);
  assign walk_len  = month_len(leap_q, idx_q);

  always_comb begin
    status_d = ST_OK;
    if (req_q == REQ_TO_YDAY) begin
      if (!(month_q inside {[MONTH_JAN:MONTH_DEC]})) begin
        status_d = ST_BAD_MONTH;
      end else if (acc_q == '0 || acc_q > {{(DAY_W-DOM_W){1'b0}}, chk_len}) begin
        status_d = ST_BAD_DAY;
      end
    end else begin
      if (acc_q == '0 || acc_q > (leap_c ? DAYS_LEAP : DAYS_YEAR)) begin
        status_d = ST_BAD_DAY;
      end
    end
  end

  always_comb begin
    if (status_q != ST_OK) begin
      walk_done = 1'b1;
    end else if (req_q == REQ_TO_YDAY) begin
      walk_done = (idx_q == month_q);
    end else begin
      walk_done = (idx_q == MONTH_DEC) ||
                  (acc_q <= {{(DAY_W-DOM_W){1'b0}}, walk_len});
    end
  end

  always_comb begin
    acc_d = acc_q;
    idx_d = idx_q;
    if (cmd_i.load) begin
      acc_d = day_number_i;
    end else if (cmd_i.check) begin
      idx_d = MONTH_JAN;
    end else if (cmd_i.step) begin
      idx_d = idx_q + 4'd1;
      if (req_q == REQ_TO_YDAY) begin
        acc_d = acc_q + {{(DAY_W-DOM_W){1'b0}}, walk_len};
      end else begin
        acc_d = acc_q - {{(DAY_W-DOM_W){1'b0}}, walk_len};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= MONTH_JAN;
      status_q <= ST_OK;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.check) begin
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      year_q  <= year_i;
      month_q <= month_in_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[YEAR_W-1:0];
    end
    if (cmd_i.check) begin
      leap_q <= leap_c;
    end
  end

  assign ok_fwd = (status_q == ST_OK) && (req_q == REQ_TO_YDAY);
  assign ok_inv = (status_q == ST_OK) && (req_q == REQ_TO_DATE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.store) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      out_status_q <= status_q;
      out_yday_q   <= ok_fwd ? acc_q : '0;
      out_month_q  <= ok_inv ? idx_q : '0;
      out_day_q    <= ok_inv ? acc_q[DOM_W-1:0] : '0;
    end
  end

  assign sts_o.walk_done = walk_done;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign year_day_o  = out_yday_q;
  assign month_out_o = out_month_q;
  assign day_out_o   = out_day_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= MONTH_DEC)
    else $error("month index beyond December");

  a_store_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |=> out_valid_q)
    else $error("stored result not presented");

endmodule

>>> verif/gregorian_day_of_year_converter_test.sv
// Self-checking testbench for gregorian_day_of_year_converter: directed table of requests,
// then constrained-by-hand random words; results are checked against typed rows or a local
// date predictor. Depends on gdoy_pkg and the converter RTL.
`timescale 1ns / 1ps

module gregorian_day_of_year_converter_test;
  import gdoy_pkg::*;

  localparam int unsigned N_RANDOM    = 1400;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned N_DIRECTED  = 24;

  typedef struct packed {
    logic              req;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [DAY_W-1:0]  dn;
  } conv_req_t;

  typedef struct packed {
    status_e          status;
    logic [DAY_W-1:0] year_day;
    logic [3:0]       month_out;
    logic [DOM_W-1:0] day_out;
  } conv_res_t;

  typedef struct packed {
    conv_req_t rq;
    logic      typed;
    conv_res_t res;
  } stim_row_t;

  localparam logic [DOM_W-1:0] DAYS_IN_MONTH [0:12] =
    '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  localparam conv_res_t NONE = '0;

  localparam stim_row_t DIR_ROWS [0:N_DIRECTED-1] = '{
    '{'{REQ_TO_YDAY, 16'd2023,  4'd1,  9'd1},   1'b1, '{ST_OK, 9'd1, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd2023,  4'd12, 9'd31},  1'b1, '{ST_OK, 9'd365, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd2024,  4'd12, 9'd31},  1'b1, '{ST_OK, 9'd366, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd2023,  4'd0,  9'd0},   1'b1, '{ST_BAD_MONTH, 9'd0, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd2023,  4'd13, 9'd15},  1'b1, '{ST_BAD_MONTH, 9'd0, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd65535, 4'd15, 9'd511}, 1'b1, '{ST_BAD_MONTH, 9'd0, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd2023,  4'd3,  9'd0},   1'b1, '{ST_BAD_DAY, 9'd0, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd1900,  4'd2,  9'd29},  1'b1, '{ST_BAD_DAY, 9'd0, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd2000,  4'd2,  9'd29},  1'b1, '{ST_OK, 9'd60, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd0,     4'd2,  9'd29},  1'b1, '{ST_OK, 9'd60, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd65535, 4'd2,  9'd29},  1'b1, '{ST_BAD_DAY, 9'd0, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd2023,  4'd1,  9'd511}, 1'b1, '{ST_BAD_DAY, 9'd0, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd2023,  4'd4,  9'd31},  1'b1, '{ST_BAD_DAY, 9'd0, 4'd0, 5'd0}},
    '{'{REQ_TO_YDAY, 16'd2100,  4'd3,  9'd1},   1'b0, NONE},
    '{'{REQ_TO_YDAY, 16'd2024,  4'd7,  9'd4},   1'b0, NONE},
    '{'{REQ_TO_DATE, 16'd2023,  4'd0,  9'd0},   1'b1, '{ST_BAD_DAY, 9'd0, 4'd0, 5'd0}},
    '{'{REQ_TO_DATE, 16'd2023,  4'd0,  9'd366}, 1'b1, '{ST_BAD_DAY, 9'd0, 4'd0, 5'd0}},
    '{'{REQ_TO_DATE, 16'd2024,  4'd0,  9'd366}, 1'b1, '{ST_OK, 9'd0, 4'd12, 5'd31}},
    '{'{REQ_TO_DATE, 16'd2023,  4'd15, 9'd1},   1'b1, '{ST_OK, 9'd0, 4'd1, 5'd1}},
    '{'{REQ_TO_DATE, 16'd0,     4'd0,  9'd511}, 1'b1, '{ST_BAD_DAY, 9'd0, 4'd0, 5'd0}},
    '{'{REQ_TO_DATE, 16'd2024,  4'd0,  9'd60},  1'b0, NONE},
    '{'{REQ_TO_DATE, 16'd2023,  4'd0,  9'd60},  1'b0, NONE},
    '{'{REQ_TO_DATE, 16'd65535, 4'd0,  9'd365}, 1'b1, '{ST_OK, 9'd0, 4'd12, 5'd31}},
    '{'{REQ_TO_DATE, 16'd1600,  4'd9,  9'd256}, 1'b0, NONE}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;  // year[15:0], month_in[19:16], day_number[28:20]
  logic [0:0]  s_axis_tuser_i = '0;  // req_type[0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;       // status[1:0], year_day[10:2], month_out[14:11],
                                     // day_out[19:15]

  conv_res_t   pending_q[$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  gregorian_day_of_year_converter dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [DOM_W-1:0] days_in(input logic leap, input logic [3:0] m);
    if (m < 1 || m > 12) return '0;
    if (m == 2 && leap) return 5'd29;
    return DAYS_IN_MONTH[m];
  endfunction

  function automatic conv_res_t convert_date(input conv_req_t rq);
    conv_res_t   r;
    logic        leap;
    int unsigned total;
    int unsigned rem;
    int unsigned m;
    r = '0;
    r.status = ST_OK;
    leap = leap_year(rq.year);
    if (rq.req == REQ_TO_YDAY) begin
      if (rq.month < 1 || rq.month > 12) begin
        r.status = ST_BAD_MONTH;
      end else if (rq.dn < 1 || rq.dn > days_in(leap, rq.month)) begin
        r.status = ST_BAD_DAY;
      end else begin
        total = 32'(rq.dn);
        for (m = 1; m < rq.month; m++) total += 32'(days_in(leap, m[3:0]));
        r.year_day = total[DAY_W-1:0];
      end
    end else begin
      total = leap ? 366 : 365;
      if (rq.dn < 1 || rq.dn > total) begin
        r.status = ST_BAD_DAY;
      end else begin
        m = 1;
        rem = 32'(rq.dn);
        while (m < 12 && rem > days_in(leap, m[3:0])) begin
          rem -= 32'(days_in(leap, m[3:0]));
          m++;
        end
        r.month_out = m[3:0];
        r.day_out = rem[DOM_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic [YEAR_W-1:0] pick_year();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 163) * 400);
      1: return 16'($urandom_range(0, 655) * 100);
      2: return 16'($urandom_range(0, 16383) * 4);
      3: return $urandom_range(0, 1) ? 16'd65535 : 16'd0;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // bursty sender: holds tvalid across a burst, drops it only for a gap
  task automatic send_word(input conv_req_t rq, input conv_res_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
    if (gap_left > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {3'b000, rq.dn, rq.month, rq.year};
    s_axis_tuser_i <= rq.req;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_q.push_back(want);
    burst_left--;
  endtask

  // receiver stall pattern rotates through four modes, from always ready to mostly stalled
  always @(posedge clk_i) begin
    case ((cycle_cnt / 300) % 4)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      2: m_axis_tready_i <= (cycle_cnt % 9) > 3;
      default: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    conv_res_t want;
    conv_res_t got;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status    = status_e'(m_axis_tdata_o[1:0]);
      got.year_day  = m_axis_tdata_o[10:2];
      got.month_out = m_axis_tdata_o[14:11];
      got.day_out   = m_axis_tdata_o[19:15];
      if (pending_q.size() == 0) begin
        if (fail_cnt < 10) $display("unexpected result word %h", m_axis_tdata_o);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (got.status != want.status || got.year_day != want.year_day ||
            got.month_out != want.month_out || got.day_out != want.day_out) begin
          if (fail_cnt < 10)
            $display("mismatch: status %0d/%0d yday %0d/%0d month %0d/%0d day %0d/%0d",
                     want.status, got.status, want.year_day, got.year_day,
                     want.month_out, got.month_out, want.day_out, got.day_out);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    conv_req_t   rq;
    logic        leap;
    int unsigned i;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_DIRECTED; i++) begin
      rq = DIR_ROWS[i].rq;
      send_word(rq, DIR_ROWS[i].typed ? DIR_ROWS[i].res : convert_date(rq));
    end

    for (i = 0; i < N_RANDOM; i++) begin
      rq.year = pick_year();
      rq.month = 4'($urandom_range(0, 15));
      rq.dn = 9'($urandom_range(0, 511));
      rq.req = 1'($urandom_range(0, 1));
      leap = leap_year(rq.year);
      // mostly well-formed dates, the rest left as raw noise
      if ($urandom_range(0, 4) != 0) begin
        if (rq.req == REQ_TO_YDAY) begin
          rq.month = 4'($urandom_range(1, 12));
          rq.dn = 9'($urandom_range(1, days_in(leap, rq.month)));
        end else begin
          rq.dn = 9'($urandom_range(1, leap ? 366 : 365));
        end
      end
      send_word(rq, convert_date(rq));
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
